@@ hw/rtl/tbr_pkg.sv @@
// Shared types and constants for the triangle/box row rasterizer.
// Used by tbr_mul_unit, tbr_edge_unit and triangle_box_row_rasterizer.
package tbr_pkg;

   localparam int COORD_W  = 8;    // vertex coordinate, signed
   localparam int DIFF_W   = 9;    // difference of two coordinates, signed
   localparam int OPA_W    = 10;   // multiplier operand A, signed
   localparam int OPB_W    = 14;   // multiplier operand B, signed
   localparam int PROD_W   = OPA_W + OPB_W;
   localparam int ACC_W    = 19;   // edge function accumulator, signed
   localparam int COLOR_W  = 32;
   localparam int CLIP_W   = 7;
   localparam int STRIDE_W = 13;
   localparam int BASE_W   = 18;
   localparam int RIDX_W   = 6;
   localparam int COV_W    = 64;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 120;
   localparam int CSR_IDX_W  = 2;

   localparam logic [STRIDE_W-1:0] STRIDE_LIMIT = 13'd4096;

   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_STRIDE  = 2'd2;

   typedef enum logic [1:0] {
      EC_HOLD,
      EC_LOAD,
      EC_STEP_X,
      EC_NEXT_ROW
   } edge_op_type;

   typedef struct packed {
      edge_op_type op;
      logic [1:0]  idx;   // edge being loaded
      logic        sub;   // subtract the product from the partial value
   } edge_cmd_type;

endpackage

@@ hw/rtl/tbr_mul_unit.sv @@
// Shared signed multiplier with registered product for setup products.
// Depends on tbr_pkg.
module tbr_mul_unit
   import tbr_pkg::*;
(
   input  logic                     clock,
   input  logic signed [OPA_W-1:0]  op_a,
   input  logic signed [OPB_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod
);

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(op_a) * PROD_W'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign prod = prod_ff;

endmodule

@@ hw/rtl/tbr_edge_unit.sv @@
// Edge function accumulators for every triangle edge, stepped across columns and rows,
// plus the inclusive either-winding coverage test. Depends on tbr_pkg.
module tbr_edge_unit
   import tbr_pkg::*;
(
   input  logic                     clock,
   input  edge_cmd_type             cmd,
   input  logic signed [PROD_W-1:0] prod,
   input  logic signed [DIFF_W-1:0] dx [3],
   input  logic signed [DIFF_W-1:0] dy [3],
   output logic                     hit
);

   logic signed [ACC_W-1:0] start_ff [3];
   logic signed [ACC_W-1:0] start_in [3];
   logic signed [ACC_W-1:0] cur_ff   [3];
   logic signed [ACC_W-1:0] cur_in   [3];
   logic signed [ACC_W-1:0] ld_val   [3];
   logic signed [ACC_W-1:0] nr_val   [3];
   logic signed [ACC_W-1:0] prod_acc;
   logic                    any_neg;
   logic                    any_pos;

   assign prod_acc = $signed(prod[ACC_W-1:0]);

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         ld_val[i] = cmd.sub ? (start_ff[i] - prod_acc) : prod_acc;
         nr_val[i] = start_ff[i] - ACC_W'(dy[i]);
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         start_in[i] = start_ff[i];
         cur_in[i]   = cur_ff[i];
      end
      case (cmd.op)
         EC_LOAD: begin
            for (int i = 0; i < 3; i++) begin
               if (cmd.idx == 2'(i)) begin
                  start_in[i] = ld_val[i];
                  cur_in[i]   = ld_val[i];
               end
            end
         end
         EC_STEP_X: begin
            for (int i = 0; i < 3; i++) begin
               cur_in[i] = cur_ff[i] + ACC_W'(dx[i]);
            end
         end
         EC_NEXT_ROW: begin
            for (int i = 0; i < 3; i++) begin
               start_in[i] = nr_val[i];
               cur_in[i]   = nr_val[i];
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         start_ff[i] <= start_in[i];
         cur_ff[i]   <= cur_in[i];
      end
   end

   // covered unless signs disagree: zero counts as either side
   assign any_neg = (cur_ff[0] < 0) || (cur_ff[1] < 0) || (cur_ff[2] < 0);
   assign any_pos = (cur_ff[0] > 0) || (cur_ff[1] > 0) || (cur_ff[2] > 0);
   assign hit     = !(any_neg && any_pos);

endmodule

@@ hw/rtl/triangle_box_row_rasterizer.sv @@
// Triangle / box row rasterizer, top level. Depends on tbr_pkg, tbr_mul_unit, tbr_edge_unit.
// After accept, a setup phase runs 7 products through the one shared multiplier; then
// each row steps the edge functions across columns x0..x1 for a triangle, or loads the
// box column mask for a box; an empty primitive skips setup and gives its single result.
// One primitive at a time; each row waits until the output register is free to take it.
// Reset (synchronous, active high) clears the sequencer, output valid and CSRs to 16/16/16.
module triangle_box_row_rasterizer
   import tbr_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 64
)
(
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // vert_a_x[7:0], vert_a_y[15:8], vert_b_x[23:16], vert_b_y[31:24],
   // vert_c_x[39:32], vert_c_y[47:40], pixel_color[79:48]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,   // op (0 triangle, 1 box)
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // row_index[5:0], row_base[23:6], coverage[87:24], out_color[119:88]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   output logic                   rsp_tlast,   // last_row
   output logic                   rsp_tuser,   // empty_res
   // configuration
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [STRIDE_W-1:0]    csr_wdata
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SETUP = 4'b0010,
      ST_PIXEL = 4'b0100,
      ST_EMIT  = 4'b1000
   } state_type;

   // ---------------------------------------------------------------- CSRs
   logic [CLIP_W-1:0]   clip_width_ff;
   logic [CLIP_W-1:0]   clip_height_ff;
   logic [STRIDE_W-1:0] row_stride_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_width_ff  <= CLIP_W'(16);
         clip_height_ff <= CLIP_W'(16);
         row_stride_ff  <= STRIDE_W'(16);
      end else if (csr_we) begin
         case (csr_index)
            CSR_CLIP_WIDTH:  clip_width_ff  <= csr_wdata[CLIP_W-1:0];
            CSR_CLIP_HEIGHT: clip_height_ff <= csr_wdata[CLIP_W-1:0];
            CSR_ROW_STRIDE:  row_stride_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // clamp limits to what the block supports
   logic [CLIP_W-1:0]   cw_eff;
   logic [CLIP_W-1:0]   ch_eff;
   logic [STRIDE_W-1:0] stride_eff;

   assign cw_eff = (clip_width_ff > CLIP_W'(MAX_WIDTH)) ? CLIP_W'(MAX_WIDTH) : clip_width_ff;
   assign ch_eff = (clip_height_ff > CLIP_W'(MAX_HEIGHT)) ? CLIP_W'(MAX_HEIGHT)
                                                          : clip_height_ff;
   assign stride_eff = (row_stride_ff > STRIDE_LIMIT) ? STRIDE_LIMIT : row_stride_ff;

   // ------------------------------------------------ bounds at accept time
   function automatic logic signed [OPA_W-1:0] smin(input logic signed [OPA_W-1:0] a,
                                                    input logic signed [OPA_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic signed [OPA_W-1:0] smax(input logic signed [OPA_W-1:0] a,
                                                    input logic signed [OPA_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic signed [OPA_W-1:0] in_x [3];
   logic signed [OPA_W-1:0] in_y [3];
   logic signed [OPA_W-1:0] cw_s;
   logic signed [OPA_W-1:0] ch_s;
   logic signed [OPA_W-1:0] bx0;
   logic signed [OPA_W-1:0] bx1;
   logic signed [OPA_W-1:0] by0;
   logic signed [OPA_W-1:0] by1;
   logic                    in_empty;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         in_x[i] = OPA_W'($signed(req_tdata[16*i +: COORD_W]));
         in_y[i] = OPA_W'($signed(req_tdata[16*i + COORD_W +: COORD_W]));
      end
   end

   assign cw_s = OPA_W'(cw_eff);
   assign ch_s = OPA_W'(ch_eff);

   always_comb begin
      if (req_tuser) begin
         // box: half-open right/bottom
         bx0 = smax(in_x[0], '0);
         bx1 = smin(in_x[1], cw_s) - OPA_W'(1);
         by0 = smax(in_y[0], '0);
         by1 = smin(in_y[1], ch_s) - OPA_W'(1);
      end else begin
         bx0 = smax(smin(in_x[0], smin(in_x[1], in_x[2])), '0);
         bx1 = smin(smax(in_x[0], smax(in_x[1], in_x[2])), cw_s - OPA_W'(1));
         by0 = smax(smin(in_y[0], smin(in_y[1], in_y[2])), '0);
         by1 = smin(smax(in_y[0], smax(in_y[1], in_y[2])), ch_s - OPA_W'(1));
      end
   end

   assign in_empty = (bx0 > bx1) || (by0 > by1);

   // ------------------------------------------------------ item registers
   state_type                 state_ff;
   state_type                 state_in;
   logic [2:0]                cnt_ff;
   logic [2:0]                cnt_in;
   logic                      op_ff;
   logic                      empty_ff;
   logic signed [COORD_W-1:0] vx_ff [3];
   logic signed [COORD_W-1:0] vy_ff [3];
   logic [COLOR_W-1:0]        color_ff;
   logic [COL_W-1:0]          x0_ff;
   logic [COL_W-1:0]          x1_ff;
   logic [ROW_W-1:0]          y0_ff;
   logic [ROW_W-1:0]          y1_ff;
   logic [COL_W-1:0]          xc_ff;
   logic [COL_W-1:0]          xc_in;
   logic [ROW_W-1:0]          yc_ff;
   logic [ROW_W-1:0]          yc_in;
   logic [MAX_WIDTH-1:0]      cov_ff;
   logic [MAX_WIDTH-1:0]      cov_in;
   logic [BASE_W-1:0]         rowbase_ff;
   logic [BASE_W-1:0]         rowbase_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      row_last;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (req_fire) begin
         op_ff    <= req_tuser;
         empty_ff <= in_empty;
         color_ff <= req_tdata[REQ_DATA_W-1 -: COLOR_W];
         for (int i = 0; i < 3; i++) begin
            vx_ff[i] <= $signed(req_tdata[16*i +: COORD_W]);
            vy_ff[i] <= $signed(req_tdata[16*i + COORD_W +: COORD_W]);
         end
         // in range whenever the primitive is not empty
         x0_ff <= bx0[COL_W-1:0];
         x1_ff <= bx1[COL_W-1:0];
         y0_ff <= by0[ROW_W-1:0];
         y1_ff <= by1[ROW_W-1:0];
      end
   end

   // ------------------------------------------- edge deltas and operands
   logic signed [DIFF_W-1:0] dx [3];
   logic signed [DIFF_W-1:0] dy [3];
   logic signed [OPA_W-1:0]  x0_s;
   logic signed [OPA_W-1:0]  y0_s;
   logic signed [OPA_W-1:0]  op_a;
   logic signed [OPB_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;

   // edge i runs from vertex i to vertex i+1 (mod 3), origin at vertex i+1
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dx[i] = DIFF_W'(vy_ff[i]) - DIFF_W'(vy_ff[(i + 1) % 3]);
         dy[i] = DIFF_W'(vx_ff[i]) - DIFF_W'(vx_ff[(i + 1) % 3]);
      end
   end

   assign x0_s = OPA_W'(x0_ff);
   assign y0_s = OPA_W'(y0_ff);

   // setup schedule: two products per edge, then the first row base
   always_comb begin
      case (cnt_ff)
         3'd0: begin
            op_a = x0_s - OPA_W'(vx_ff[1]);
            op_b = OPB_W'(dx[0]);
         end
         3'd1: begin
            op_a = y0_s - OPA_W'(vy_ff[1]);
            op_b = OPB_W'(dy[0]);
         end
         3'd2: begin
            op_a = x0_s - OPA_W'(vx_ff[2]);
            op_b = OPB_W'(dx[1]);
         end
         3'd3: begin
            op_a = y0_s - OPA_W'(vy_ff[2]);
            op_b = OPB_W'(dy[1]);
         end
         3'd4: begin
            op_a = x0_s - OPA_W'(vx_ff[0]);
            op_b = OPB_W'(dx[2]);
         end
         3'd5: begin
            op_a = y0_s - OPA_W'(vy_ff[0]);
            op_b = OPB_W'(dy[2]);
         end
         default: begin
            op_a = y0_s;
            op_b = OPB_W'(stride_eff);
         end
      endcase
   end

   tbr_mul_unit u_mul (
      .clock (clock),
      .op_a  (op_a),
      .op_b  (op_b),
      .prod  (prod)
   );

   // ------------------------------------------------------ edge stepping
   edge_cmd_type edge_cmd;
   logic [2:0]   prev_cnt;
   logic         pix_hit;

   assign prev_cnt = cnt_ff - 3'd1;

   tbr_edge_unit u_edge (
      .clock (clock),
      .cmd   (edge_cmd),
      .prod  (prod),
      .dx    (dx),
      .dy    (dy),
      .hit   (pix_hit)
   );

   // box coverage: columns x0..x1
   logic [MAX_WIDTH-1:0] box_mask;

   always_comb begin
      for (int i = 0; i < MAX_WIDTH; i++) begin
         box_mask[i] = (COL_W'(i) >= x0_ff) && (COL_W'(i) <= x1_ff);
      end
   end

   // ------------------------------------------------------- sequencer
   assign out_free = !rsp_tvalid || rsp_tready;
   assign row_last = empty_ff || (yc_ff == y1_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      xc_in        = xc_ff;
      yc_in        = yc_ff;
      cov_in       = cov_ff;
      rowbase_in   = rowbase_ff;
      edge_cmd     = '{op: EC_HOLD, idx: 2'd0, sub: 1'b0};
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cnt_in   = 3'd0;
               state_in = in_empty ? ST_EMIT : ST_SETUP;
            end
         end
         ST_SETUP: begin
            cnt_in = cnt_ff + 3'd1;
            // products land in the cycle after their operands
            if (cnt_ff != 3'd0 && cnt_ff != 3'd7) begin
               edge_cmd = '{op: EC_LOAD, idx: prev_cnt[2:1], sub: prev_cnt[0]};
            end
            if (cnt_ff == 3'd7) begin
               rowbase_in = prod[BASE_W-1:0];
               xc_in      = x0_ff;
               yc_in      = y0_ff;
               cov_in     = '0;
               state_in   = ST_PIXEL;
            end
         end
         ST_PIXEL: begin
            if (op_ff) begin
               cov_in   = box_mask;
               state_in = ST_EMIT;
            end else begin
               cov_in = cov_ff | (MAX_WIDTH'(pix_hit) << xc_ff);
               if (xc_ff == x1_ff) begin
                  state_in = ST_EMIT;
               end else begin
                  xc_in    = xc_ff + COL_W'(1);
                  edge_cmd = '{op: EC_STEP_X, idx: 2'd0, sub: 1'b0};
               end
            end
         end
         ST_EMIT: begin
            // hold until the output register can take the row
            if (out_free) begin
               if (row_last) begin
                  state_in = ST_IDLE;
               end else begin
                  yc_in      = yc_ff + ROW_W'(1);
                  xc_in      = x0_ff;
                  cov_in     = '0;
                  rowbase_in = rowbase_ff + BASE_W'(stride_eff);
                  edge_cmd   = '{op: EC_NEXT_ROW, idx: 2'd0, sub: 1'b0};
                  state_in   = ST_PIXEL;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= 3'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff      <= xc_in;
      yc_ff      <= yc_in;
      cov_ff     <= cov_in;
      rowbase_ff <= rowbase_in;
   end

   // --------------------------------------------------- output register
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   logic [RSP_DATA_W-1:0] rsp_data_in;
   logic                  rsp_last_ff;
   logic                  rsp_empty_ff;
   logic                  emit_load;

   assign emit_load = (state_ff == ST_EMIT) && out_free;

   always_comb begin
      if (empty_ff) begin
         rsp_data_in = {color_ff, COV_W'(0), BASE_W'(0), RIDX_W'(0)};
      end else begin
         rsp_data_in = {color_ff, COV_W'(cov_ff), rowbase_ff, RIDX_W'(yc_ff)};
      end
   end

   always_comb begin
      if (emit_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_load) begin
         rsp_data_ff  <= rsp_data_in;
         rsp_last_ff  <= row_last;
         rsp_empty_ff <= empty_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // -------------------------------------------------------- assertions
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while previous primitive still in work");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tlast && (rsp_tdata[87:24] == '0))
      else $error("empty result not marked last or has coverage");

   a_column_in_box: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PIXEL) && !op_ff |-> (xc_ff >= x0_ff) && (xc_ff <= x1_ff))
      else $error("column counter left the clipped column range");

endmodule
